[rtl/hcs_pkg.sv]
// Shared types, register indexes and default sizes for the Harris corner strength block.
// No dependencies; every other file imports it.
package hcs_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_WINDOW = 7;

   localparam int GRAD_W     = 8;
   localparam int STRENGTH_W = 47;
   localparam int PIX_COL_W  = 11;
   localparam int PIX_ROW_W  = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 47;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_K_COEFF      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SHIFT,
      ST_SUM,
      ST_MUL1,
      ST_MUL2,
      ST_OUT
   } hcs_state_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } hcs_cell_ctl_type;

endpackage

[rtl/hcs_req_if.sv]
// Input and result channel interfaces for the Harris corner strength block.
// Depends on hcs_pkg for field widths.
interface hcs_req_if import hcs_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [GRAD_W-1:0] grad_x;
   logic [GRAD_W-1:0] grad_y;
   modport source (output valid, grad_x, grad_y, input ready);
   modport sink   (input valid, grad_x, grad_y, output ready);
endinterface

interface hcs_rsp_if import hcs_pkg::*; ;
   logic                        valid;
   logic                        ready;
   logic signed [STRENGTH_W-1:0] strength;
   logic [PIX_COL_W-1:0]         pixel_col;
   logic [PIX_ROW_W-1:0]         pixel_row;
   logic                         frame_end;
   modport source (output valid, strength, pixel_col, pixel_row, frame_end, input ready);
   modport sink   (input valid, strength, pixel_col, pixel_row, frame_end, output ready);
endinterface

[rtl/harris_corner_strength_top.sv]
// Top level of the Harris corner strength block.
// Depends on hcs_pkg, hcs_req_if/hcs_rsp_if and hcs_cell.

// Harris corner strength: send gradient beats (grad_x, grad_y) in raster order over a
// padded grid of (frame_width + half) by (frame_height + half) positions, half being
// (window_size-1)/2; padding values are ignored. Each beat writes its pixel to a line
// store of MAX_WINDOW rows, then reads its column of the window from that store one row
// per cycle and shifts the column sums into a chain of MAX_WINDOW cells; the newest
// 2*half + 1 cells are added in a sum stage and det - floor(k*trace^2/2^16) is formed in
// two multiply stages. A beat that yields no response returns to idle after its shift;
// one that does passes the sum, multiply and output states, and the output state holds
// while the output register is still full and rsp ready is low.
// A finished response waits in an output register while the next beat is taken.
// Responses not above strength_threshold read as zero. Writes to frame_width,
// frame_height or window_size restart the scan at a new frame; write registers only
// while the block is idle. The line store is not cleared at reset.
module harris_corner_strength_top import hcs_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   hcs_req_if.sink               req_bus,
   hcs_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // sizes derived from the parameters
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = CW + 1;
   localparam int HW   = $clog2(MAX_HEIGHT) + 1;
   localparam int SB   = $clog2(MAX_WINDOW);
   localparam int DEPTH = MAX_WINDOW * (1 << CW);
   localparam int CSW  = $clog2(MAX_WINDOW * 65025 + 1);
   localparam int SW   = $clog2(MAX_WINDOW * MAX_WINDOW * 65025 + 1);
   localparam int LH   = SW + 1;
   localparam int TW   = 2 * SW + 2;
   localparam int KW   = TW + 17;
   localparam int PW   = (2 * SW + 4 > 48) ? 2 * SW + 4 : 48;
   localparam logic [15:0] MAXW16 = 16'(MAX_WIDTH);
   localparam logic [15:0] MAXH16 = 16'(MAX_HEIGHT);
   localparam logic [2:0]  HALF_CAP = 3'((MAX_WINDOW - 1) / 2);
   localparam logic [SB+1:0] MW_EXT = (SB+2)'(MAX_WINDOW);
   localparam logic [SB-1:0] SLOT_LAST = SB'(MAX_WINDOW - 1);

   // configuration registers
   logic [11:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [2:0]  window_size_ff;
   logic [15:0] k_coeff_ff;
   logic [46:0] threshold_ff;
   logic        geom_wr;

   assign geom_wr = csr_we && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT ||
                               csr_index == REG_WINDOW_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 12'd2048;
         frame_height_ff <= 13'd4096;
         window_size_ff  <= 3'd3;
         k_coeff_ff      <= 16'd2621;
         threshold_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[11:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[12:0];
            REG_WINDOW_SIZE:  window_size_ff  <= csr_wdata[2:0];
            REG_K_COEFF:      k_coeff_ff      <= csr_wdata[15:0];
            REG_THRESHOLD:    threshold_ff    <= csr_wdata[46:0];
            default: ;
         endcase
      end
   end

   // effective geometry: clamp width/height, derive half window
   logic [15:0]  fw16, fh16;
   logic [WW-1:0] w_eff, pw;
   logic [HW-1:0] h_eff, ph;
   logic [2:0]   half_raw, half;
   logic [3:0]   span;

   always_comb begin
      fw16 = {4'b0, frame_width_ff};
      fh16 = {3'b0, frame_height_ff};
      if (fw16 == 16'd0)      w_eff = WW'(1);
      else if (fw16 > MAXW16) w_eff = WW'(MAX_WIDTH);
      else                    w_eff = WW'(fw16);
      if (fh16 == 16'd0)      h_eff = HW'(1);
      else if (fh16 > MAXH16) h_eff = HW'(MAX_HEIGHT);
      else                    h_eff = HW'(fh16);
      half_raw = (window_size_ff == 3'd0) ? 3'd0 : ((window_size_ff - 3'd1) >> 1);
      half     = (half_raw > HALF_CAP) ? HALF_CAP : half_raw;
      span     = {half, 1'b0};
      pw       = w_eff + WW'(half);
      ph       = h_eff + HW'(half);
   end

   // state machine
   hcs_state_type state_ff, state_in;
   logic [3:0]    cnt_ff;
   logic          emit_ff;
   logic          rsp_valid_ff;
   logic          req_ready;
   logic          accept;
   logic          rd_issue;
   logic          cell_shift;
   logic          out_load;

   assign accept = req_bus.valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_READ;
         ST_READ:  if (cnt_ff == span) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_SHIFT;
         ST_SHIFT: state_in = emit_ff ? ST_SUM : ST_IDLE;
         ST_SUM:   state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rd_issue   = 1'b0;
      cell_shift = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready  = 1'b1;
         ST_READ:  rd_issue   = 1'b1;
         ST_SHIFT: cell_shift = 1'b1;
         ST_OUT:   out_load   = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   assign req_bus.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // scan position
   logic [WW-1:0] col_ff;
   logic [HW-1:0] row_ff;
   logic [SB-1:0] slot_ff;
   logic          col_wrap, row_wrap;

   assign col_wrap = (col_ff + WW'(1)) >= pw;
   assign row_wrap = (row_ff + HW'(1)) >= ph;

   always_ff @(posedge clock) begin
      if (reset || geom_wr) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_ff <= '0;
            if (row_wrap) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= row_ff + HW'(1);
               slot_ff <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + SB'(1);
            end
         end else begin
            col_ff <= col_ff + WW'(1);
         end
      end
   end

   // hold the beat's position and tags while it works
   logic [WW-1:0]        cur_col_ff;
   logic [HW-1:0]        cur_row_ff;
   logic [SB-1:0]        cur_slot_ff;
   logic [PIX_COL_W-1:0] tag_col_ff;
   logic [PIX_ROW_W-1:0] tag_row_ff;
   logic                 tag_end_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_col_ff  <= col_ff;
         cur_row_ff  <= row_ff;
         cur_slot_ff <= slot_ff;
         tag_col_ff  <= PIX_COL_W'(col_ff - WW'(half));
         tag_row_ff  <= PIX_ROW_W'(row_ff - HW'(half));
         tag_end_ff  <= col_wrap && row_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)       emit_ff <= 1'b0;
      else if (accept) emit_ff <= (col_ff >= WW'(half)) && (row_ff >= HW'(half));
   end

   // line store: MAX_WINDOW rows used as a ring
   logic [2*GRAD_W-1:0] line_mem [DEPTH];
   logic [2*GRAD_W-1:0] rd_data_ff;
   logic [SB+1:0]       rd_slot_sum;
   logic [SB-1:0]       rd_slot;
   logic [HW:0]         row_plus;
   logic                row_ok;

   always_ff @(posedge clock) begin
      if (accept && col_ff < w_eff && row_ff < h_eff)
         line_mem[{slot_ff, col_ff[CW-1:0]}] <= {req_bus.grad_y, req_bus.grad_x};
   end

   always_comb begin
      rd_slot_sum = (SB+2)'(cur_slot_ff) + MW_EXT - (SB+2)'(span) + (SB+2)'(cnt_ff);
      rd_slot     = (rd_slot_sum >= MW_EXT) ? SB'(rd_slot_sum - MW_EXT) : SB'(rd_slot_sum);
      row_plus    = (HW+1)'(cur_row_ff) + (HW+1)'(cnt_ff);
      row_ok      = (row_plus >= (HW+1)'(span)) &&
                    (row_plus < (HW+1)'(h_eff) + (HW+1)'(span)) && (cur_col_ff < w_eff);
   end

   always_ff @(posedge clock) begin
      if (rd_issue) rd_data_ff <= line_mem[{rd_slot, cur_col_ff[CW-1:0]}];
   end

   // read counter and pending flag
   logic rd_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_issue && row_ok;
         if (accept)        cnt_ff <= '0;
         else if (rd_issue) cnt_ff <= cnt_ff + 4'd1;
      end
   end

   // column accumulation
   logic [CSW-1:0] acc_xx_ff, acc_yy_ff, acc_xy_ff;
   logic [2*GRAD_W-1:0] sq_xx, sq_yy, sq_xy;

   assign sq_xx = rd_data_ff[7:0]  * rd_data_ff[7:0];
   assign sq_yy = rd_data_ff[15:8] * rd_data_ff[15:8];
   assign sq_xy = rd_data_ff[7:0]  * rd_data_ff[15:8];

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_xx_ff <= '0;
         acc_yy_ff <= '0;
         acc_xy_ff <= '0;
      end else if (rd_pend_ff) begin
         acc_xx_ff <= acc_xx_ff + CSW'(sq_xx);
         acc_yy_ff <= acc_yy_ff + CSW'(sq_yy);
         acc_xy_ff <= acc_xy_ff + CSW'(sq_xy);
      end
   end

   // chain of column cells, newest column in cell 0
   logic [CSW-1:0] col_xx [MAX_WINDOW];
   logic [CSW-1:0] col_yy [MAX_WINDOW];
   logic [CSW-1:0] col_xy [MAX_WINDOW];

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_chain
      hcs_cell_ctl_type cell_ctl;
      assign cell_ctl.shift = cell_shift;
      if (i == 0) begin : g_head
         assign cell_ctl.clear = 1'b0;
         hcs_cell #(.CSW(CSW)) u_cell (
            .clock   (clock),
            .ctl     (cell_ctl),
            .prev_xx (acc_xx_ff),
            .prev_yy (acc_yy_ff),
            .prev_xy (acc_xy_ff),
            .col_xx  (col_xx[i]),
            .col_yy  (col_yy[i]),
            .col_xy  (col_xy[i])
         );
      end else begin : g_body
         // columns left of the frame add zero: flush at the start of each row
         assign cell_ctl.clear = (cur_col_ff == '0);
         hcs_cell #(.CSW(CSW)) u_cell (
            .clock   (clock),
            .ctl     (cell_ctl),
            .prev_xx (col_xx[i-1]),
            .prev_yy (col_yy[i-1]),
            .prev_xy (col_xy[i-1]),
            .col_xx  (col_xx[i]),
            .col_yy  (col_yy[i]),
            .col_xy  (col_xy[i])
         );
      end
   end

   // window sums over the newest span+1 cells
   logic [SW-1:0] win_xx, win_yy, win_xy;
   logic [SW-1:0] sxx_ff, syy_ff, sxy_ff;

   always_comb begin
      win_xx = '0;
      win_yy = '0;
      win_xy = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (4'(i) <= span) begin
            win_xx = win_xx + SW'(col_xx[i]);
            win_yy = win_yy + SW'(col_yy[i]);
            win_xy = win_xy + SW'(col_xy[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         sxx_ff <= win_xx;
         syy_ff <= win_yy;
         sxy_ff <= win_xy;
      end
   end

   // response arithmetic
   logic [2*SW-1:0]     p_diag_ff, p_cross_ff;
   logic [TW-1:0]       trsq_ff;
   logic [SW:0]         trace;
   logic signed [2*SW:0] det_ff;
   logic [15+LH:0]      k_lo_ff, k_hi_ff;
   logic [KW-1:0]       k_sum;
   logic [TW-1:0]       k_term;
   logic signed [PW-1:0] resp, thr_ext;

   assign trace = (SW+1)'(sxx_ff) + (SW+1)'(syy_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL1) begin
         p_diag_ff  <= sxx_ff * syy_ff;
         p_cross_ff <= sxy_ff * sxy_ff;
         trsq_ff    <= TW'(trace * trace);
      end
      if (state_ff == ST_MUL2) begin
         det_ff  <= $signed({1'b0, p_diag_ff}) - $signed({1'b0, p_cross_ff});
         k_lo_ff <= k_coeff_ff * trsq_ff[LH-1:0];
         k_hi_ff <= k_coeff_ff * trsq_ff[TW-1:LH];
      end
   end

   always_comb begin
      k_sum   = (KW'(k_hi_ff) << LH) + KW'(k_lo_ff);
      k_term  = TW'(k_sum >> 16);
      resp    = PW'(det_ff) - $signed(PW'(k_term));
      thr_ext = PW'($signed(threshold_ff));
   end

   // output register
   logic signed [STRENGTH_W-1:0] strength_ff;
   logic [PIX_COL_W-1:0]         out_col_ff;
   logic [PIX_ROW_W-1:0]         out_row_ff;
   logic                         out_end_ff;

   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (out_load)      rsp_valid_ff <= 1'b1;
      else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         strength_ff <= (resp > thr_ext) ? STRENGTH_W'(resp) : '0;
         out_col_ff  <= tag_col_ff;
         out_row_ff  <= tag_row_ff;
         out_end_ff  <= tag_end_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.strength  = strength_ff;
   assign rsp_bus.pixel_col = out_col_ff;
   assign rsp_bus.pixel_row = out_row_ff;
   assign rsp_bus.frame_end = out_end_ff;

endmodule

[rtl/hcs_cell.sv]
// One column cell of the window chain: holds the column sums of gx*gx, gy*gy, gx*gy.
// Depends on hcs_pkg for the cell control struct.
module hcs_cell import hcs_pkg::*; #(
   parameter int CSW = 20
) (
   input  logic             clock,
   input  hcs_cell_ctl_type ctl,
   input  logic [CSW-1:0]   prev_xx,
   input  logic [CSW-1:0]   prev_yy,
   input  logic [CSW-1:0]   prev_xy,
   output logic [CSW-1:0]   col_xx,
   output logic [CSW-1:0]   col_yy,
   output logic [CSW-1:0]   col_xy
);

   logic [CSW-1:0] xx_ff, yy_ff, xy_ff;

   // take the neighbor's sums, or drop to zero at the start of a row
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         xx_ff <= ctl.clear ? '0 : prev_xx;
         yy_ff <= ctl.clear ? '0 : prev_yy;
         xy_ff <= ctl.clear ? '0 : prev_xy;
      end
   end

   assign col_xx = xx_ff;
   assign col_yy = yy_ff;
   assign col_xy = xy_ff;

endmodule

[bench/hcs_strength_checker.sv]
// Watches the gradient and response channels of the Harris corner strength block,
// predicts each response from its own line store copy and compares field by field.
// Depends on hcs_pkg and the hcs_req_if / hcs_rsp_if interfaces.
module hcs_strength_checker import hcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hcs_req_if                    req_mon,
   hcs_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count
);

   typedef struct {
      logic signed [STRENGTH_W-1:0] strength;
      logic [PIX_COL_W-1:0]         pixel_col;
      logic [PIX_ROW_W-1:0]         pixel_row;
      logic                         frame_end;
   } strength_beat_type;

   localparam int LS_ROWS = DEF_MAX_WINDOW;
   localparam int LS_COLS = DEF_MAX_WIDTH;

   logic [15:0]                  line_copy [LS_ROWS*LS_COLS];
   logic [11:0]                  frame_width_q;
   logic [12:0]                  frame_height_q;
   logic [2:0]                   window_size_q;
   logic [15:0]                  k_coeff_q;
   logic signed [STRENGTH_W-1:0] threshold_q;
   int                           scan_col;
   int                           scan_row;
   strength_beat_type            awaited_strengths [$];

   // predict the response (if any) caused by one accepted gradient beat
   task automatic predict_strength(input logic [7:0] gx, input logic [7:0] gy);
      int                w, h, half, cap;
      longint            sxx, syy, sxy, det, resp, thr;
      longint unsigned   tr, kt;
      int                row, col;
      logic [15:0]       ls_word;
      strength_beat_type exp_beat;
      w = (frame_width_q < 1) ? 1 : (frame_width_q > LS_COLS) ? LS_COLS : frame_width_q;
      h = (frame_height_q < 1) ? 1 :
          (frame_height_q > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : frame_height_q;
      half = (window_size_q == 0) ? 0 : (window_size_q - 1) / 2;
      cap = (LS_ROWS - 1) / 2;
      if (half > cap) half = cap;
      if (scan_col < w && scan_row < h)
         line_copy[(scan_row % LS_ROWS) * LS_COLS + scan_col] = {gy, gx};
      if (scan_col >= half && scan_row >= half && scan_col < w + half &&
          scan_row < h + half) begin
         sxx = 0; syy = 0; sxy = 0;
         for (int dr = 0; dr <= 2 * half; dr++) begin
            row = scan_row - 2 * half + dr;
            if (row < 0 || row >= h) continue;
            for (int dc = 0; dc <= 2 * half; dc++) begin
               col = scan_col - 2 * half + dc;
               if (col < 0 || col >= w) continue;
               ls_word = line_copy[(row % LS_ROWS) * LS_COLS + col];
               sxx += ls_word[7:0] * ls_word[7:0];
               syy += ls_word[15:8] * ls_word[15:8];
               sxy += ls_word[7:0] * ls_word[15:8];
            end
         end
         det = sxx * syy - sxy * sxy;
         tr = sxx + syy;
         kt = (longint'(k_coeff_q) * (tr * tr)) >> 16;
         resp = det - longint'(kt);
         thr = threshold_q;
         exp_beat.strength = (resp > thr) ? resp[STRENGTH_W-1:0] : '0;
         exp_beat.pixel_col = PIX_COL_W'(scan_col - half);
         exp_beat.pixel_row = PIX_ROW_W'(scan_row - half);
         exp_beat.frame_end = (scan_col + 1 == w + half) && (scan_row + 1 == h + half);
         awaited_strengths.push_back(exp_beat);
      end
      scan_col++;
      if (scan_col >= w + half) begin
         scan_col = 0;
         scan_row++;
         if (scan_row >= h + half) scan_row = 0;
      end
   endtask

   always @(posedge clock) begin
      strength_beat_type exp_beat;
      if (reset) begin
         frame_width_q <= 12'd2048;
         frame_height_q <= 13'd4096;
         window_size_q <= 3'd3;
         k_coeff_q <= 16'd2621;
         threshold_q <= '0;
         scan_col = 0;
         scan_row = 0;
         fail_count = 0;
         checked_count = 0;
         awaited_strengths.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FRAME_WIDTH:  frame_width_q <= csr_wdata[11:0];
               REG_FRAME_HEIGHT: frame_height_q <= csr_wdata[12:0];
               REG_WINDOW_SIZE:  window_size_q <= csr_wdata[2:0];
               REG_K_COEFF:      k_coeff_q <= csr_wdata[15:0];
               REG_THRESHOLD:    threshold_q <= csr_wdata;
               default: ;
            endcase
            if (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT ||
                csr_index == REG_WINDOW_SIZE) begin
               scan_col = 0;
               scan_row = 0;
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_strength(req_mon.grad_x, req_mon.grad_y);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_strengths.size() == 0) begin
               $display("%0t: expected no response, actual strength=%0d col=%0d row=%0d",
                        $time, rsp_mon.strength, rsp_mon.pixel_col, rsp_mon.pixel_row);
               fail_count++;
            end else begin
               exp_beat = awaited_strengths.pop_front();
               checked_count++;
               if (rsp_mon.strength !== exp_beat.strength) begin
                  $display("%0t: strength expected %0d actual %0d", $time,
                           exp_beat.strength, rsp_mon.strength);
                  fail_count++;
               end
               if (rsp_mon.pixel_col !== exp_beat.pixel_col) begin
                  $display("%0t: pixel_col expected %0d actual %0d", $time,
                           exp_beat.pixel_col, rsp_mon.pixel_col);
                  fail_count++;
               end
               if (rsp_mon.pixel_row !== exp_beat.pixel_row) begin
                  $display("%0t: pixel_row expected %0d actual %0d", $time,
                           exp_beat.pixel_row, rsp_mon.pixel_row);
                  fail_count++;
               end
               if (rsp_mon.frame_end !== exp_beat.frame_end) begin
                  $display("%0t: frame_end expected %0b actual %0b", $time,
                           exp_beat.frame_end, rsp_mon.frame_end);
                  fail_count++;
               end
            end
         end
      end
      pending_count = awaited_strengths.size();
   end

endmodule

[bench/harris_corner_strength_top_tb.sv]
// Stimulus and verdict for the Harris corner strength block: whole padded frames
// under changing geometry, k and threshold. Depends on hcs_pkg, the channel
// interfaces, harris_corner_strength_top and hcs_strength_checker.
module harris_corner_strength_top_tb;
   import hcs_pkg::*;

   localparam int DRAIN_CYCLES = 24;   // longer than one no-response beat at window 7
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;   // no register behind it

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    checked_count;
   int                    sender_idle_pct;
   int                    recv_idle_pct;
   bit                    hold_rsp;
   int                    random_beats;
   int                    frames_sent;

   hcs_req_if req_bus ();
   hcs_rsp_if rsp_bus ();

   harris_corner_strength_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hcs_strength_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // receiver: random ready, or one long hold-off counted here so the block backs up
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // load one register; csr_we stays high across back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(posedge clock);
   endtask

   // offer one gradient beat, maybe after a random gap, and hold until accepted
   task automatic send_beat(input logic [7:0] gx, input logic [7:0] gy);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.grad_x <= gx;
      req_bus.grad_y <= gy;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drop valid and wait until every predicted response is back, then let the
   // block finish any beat that yields no response
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // configure, then stream one padded frame (or only its first limit beats when
   // limit is above zero); pattern 0 random, 1 all ones, 2 all zero,
   // 3 alternating gx/gy extremes
   task automatic run_frame(input int w, input int h, input int win, input int k,
                            input logic [CSR_DATA_W-1:0] thr, input int pattern,
                            input int limit);
      int ew, eh, half, n;
      logic [7:0] gx, gy;
      write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_WINDOW_SIZE, CSR_DATA_W'(win));
      write_reg(REG_K_COEFF, CSR_DATA_W'(k));
      write_reg(REG_THRESHOLD, thr);
      csr_we <= 1'b0;
      @(posedge clock);
      ew = (w[11:0] < 1) ? 1 : (w[11:0] > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w[11:0];
      eh = (h[12:0] < 1) ? 1 : (h[12:0] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h[12:0];
      half = (win[2:0] == 0) ? 0 : (win[2:0] - 1) / 2;
      n = (ew + half) * (eh + half);
      if (limit > 0 && limit < n) n = limit;
      for (int i = 0; i < n; i++) begin
         case (pattern)
            1: begin gx = 8'hFF; gy = 8'hFF; end
            2: begin gx = 8'h00; gy = 8'h00; end
            3: begin gx = i[0] ? 8'hFF : 8'h00; gy = i[0] ? 8'h00 : 8'hFF; end
            default: begin gx = 8'($urandom_range(255)); gy = 8'($urandom_range(255)); end
         endcase
         send_beat(gx, gy);
      end
      if (pattern == 0) random_beats += n;
      frames_sent++;
      wait_drained();
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_threshold();
      case ($urandom_range(3))
         0: return '0;
         1: return CSR_DATA_W'({$urandom, $urandom});
         2: return {{27{1'b1}}, 20'($urandom)};   // small negative
         default: return 47'($urandom_range(1 << 20));
      endcase
   endfunction

   function automatic int pick_k();
      case ($urandom_range(3))
         0: return 0;
         1: return 65535;
         2: return 2621;
         default: return $urandom_range(65535);
      endcase
   endfunction

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.grad_x <= '0;
      req_bus.grad_y <= '0;
      hold_rsp = 1'b0;
      sender_idle_pct = 35;
      recv_idle_pct = 66;
      random_beats = 0;
      frames_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: saturated and alternating gradients, k and threshold extremes,
      // single-pixel frame, and a write to an unused register index (ignored)
      write_reg(REG_SPARE, '1);
      run_frame(2, 2, 3, 65535, 47'h4000_0000_0000, 3, 0);
      run_frame(3, 2, 3, 0, 47'h3FFF_FFFF_FFFF, 1, 0);
      run_frame(1, 1, 1, 2621, 47'h4000_0000_0000, 2, 0);

      // random frames; first one runs into a long receiver hold-off
      hold_rsp = 1'b1;
      while (random_beats < 400) begin
         if (random_beats >= 260) begin
            sender_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_beats >= 130) begin
            sender_idle_pct = 66;
            recv_idle_pct = 35;
         end
         run_frame($urandom_range(1, 10), $urandom_range(1, 6), $urandom_range(7),
                   pick_k(), pick_threshold(), 0, 0);
      end

      // geometry extremes: oversize width/height clamp (first beats of the frame
      // only, cut short by the next geometry write), zero width/window
      run_frame(4095, 1, 1, 65535, '0, 0, 24);
      run_frame(0, 8191, 0, 0, 47'h4000_0000_0000, 0, 24);
      run_frame(5, 4, 7, 2621, '0, 0, 0);
      run_frame(6, 3, 6, pick_k(), pick_threshold(), 0, 0);

      $display("Covered %0d frames, %0d random beats, %0d responses checked.",
               frames_sent, random_beats, checked_count);
      $display("Geometry from 1x1 to clamped width/height, windows 0..7, k and threshold extremes.");
      if (fail_count == 0) begin
         $display("** harris_corner_strength_top: PASSED **");
      end else begin
         $display("** harris_corner_strength_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timeout with %0d responses outstanding", pending_count);
      $display("** harris_corner_strength_top: FAILED **");
      $finish;
   end

endmodule
